// ===== rtl/assert_macros.svh =====
// assertion macros used by roberts_edge_magnitude.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rbe_pkg.sv =====
// types and constants of the roberts edge magnitude block
`default_nettype none

package rbe_pkg;

  // line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = COL_W + 1;
  localparam int ROW_W     = 16;
  localparam int MIN_DIM   = 3;

  // payload widths
  localparam int PIXEL_W = 8;
  localparam int EDGE_W  = 9;

  // gradient arithmetic widths
  localparam int SQ_W  = 2 * PIXEL_W;
  localparam int SUM_W = SQ_W + 1;
  localparam logic [SUM_W-1:0] ROOT_START = {1'b1, {(SUM_W-1){1'b0}}};

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_MODE     = 2'd2;

  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = 16'd480;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/rbe_if.sv =====
// channel interfaces of the roberts edge magnitude block
`default_nettype none

// pixel input channel
interface rbe_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rbe_pkg::PIXEL_W-1:0] pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

// gradient result channel
interface rbe_res_if;
  logic                       valid;
  logic                       ready;
  logic [rbe_pkg::EDGE_W-1:0] edge_value;
  logic                       interior;
  logic                       end_of_frame;

  modport source(output valid, output edge_value, output interior, output end_of_frame,
                 input ready);
  modport sink(input valid, input edge_value, input interior, input end_of_frame,
               output ready);
endinterface

// register write channel
interface rbe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rbe_pkg::CFG_IDX_W-1:0]  index;
  logic [rbe_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rbe_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module rbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/roberts_edge_magnitude.sv =====
// roberts cross edge detector over a raster pixel stream
//
//   channel | dir | beat payload                        | handshake
//   in_bus  | in  | pixel                               | valid / ready
//   out_bus | out | edge_value, interior, end_of_frame  | valid / ready
//   cfg_bus | in  | index, data                         | valid / ready
//
// an accepted pixel goes from ST_CALC to ST_DONE when it is a border pixel
// or abs_mode is set, and passes ST_SUM and ST_ROOT first in root mode:
// the bit-serial square root settles one result bit per cycle (9 steps).
// after reset a full address sweep clears the line store; no pixel is taken
// then, register writes are. the output register holds a result while the
// next pixel is accepted; a finished result waits until that register frees.
`default_nettype none

`include "assert_macros.svh"

module roberts_edge_magnitude (
  input wire logic clk,
  input wire logic rst_n,
  rbe_pix_if.sink   in_bus,
  rbe_res_if.source out_bus,
  rbe_cfg_if.sink   cfg_bus
);

  // configuration registers
  logic [rbe_pkg::FW_W-1:0]  fw_r;
  logic [rbe_pkg::ROW_W-1:0] fh_r;
  logic                      abs_r;

  // sequencer and position
  rbe_pkg::state_t           state_r, state_nxt;
  logic [rbe_pkg::COL_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [rbe_pkg::COL_W-1:0] col_r, col_nxt;
  logic [rbe_pkg::ROW_W-1:0] row_r, row_nxt;

  // window and item registers
  logic [rbe_pkg::PIXEL_W-1:0] left_now_r, left_now_nxt;
  logic [rbe_pkg::PIXEL_W-1:0] left_above_r, left_above_nxt;
  logic [rbe_pkg::PIXEL_W-1:0] pix_r, pix_nxt;
  logic [rbe_pkg::COL_W-1:0]   addr_r, addr_nxt;
  logic                        inner_r, inner_nxt;
  logic                        last_r, last_nxt;

  // gradient datapath
  logic [rbe_pkg::SQ_W-1:0]   sq1_r, sq1_nxt;
  logic [rbe_pkg::SQ_W-1:0]   sq2_r, sq2_nxt;
  logic [rbe_pkg::SUM_W-1:0]  rem_r, rem_nxt;
  logic [rbe_pkg::SUM_W-1:0]  res_r, res_nxt;
  logic [rbe_pkg::SUM_W-1:0]  bit_r, bit_nxt;
  logic [rbe_pkg::EDGE_W-1:0] val_r, val_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [rbe_pkg::EDGE_W-1:0] out_edge_r, out_edge_nxt;
  logic                       out_inner_r, out_inner_nxt;
  logic                       out_last_r, out_last_nxt;

  // line store port
  logic                        ram_we;
  logic [rbe_pkg::COL_W-1:0]   ram_waddr;
  logic [rbe_pkg::PIXEL_W-1:0] ram_wdata;
  logic [rbe_pkg::COL_W-1:0]   ram_raddr;
  logic [rbe_pkg::PIXEL_W-1:0] ram_rdata;

  // combinational helpers
  logic [rbe_pkg::FW_W-1:0]    w_eff;
  logic [rbe_pkg::ROW_W-1:0]   h_eff;
  logic                        col_wrap;
  logic [rbe_pkg::ROW_W:0]     row_step;
  logic [rbe_pkg::COL_W-1:0]   c_sel;
  logic [rbe_pkg::ROW_W-1:0]   r_sel;
  logic [rbe_pkg::FW_W-1:0]    c_inc;
  logic [rbe_pkg::ROW_W:0]     r_inc;
  logic                        in_acc;
  logic                        out_free;
  logic [rbe_pkg::PIXEL_W:0]   d1, d2;
  logic [rbe_pkg::PIXEL_W-1:0] a1, a2;
  logic [rbe_pkg::SUM_W:0]     root_try;
  logic                        root_ge;
  logic [rbe_pkg::SUM_W-1:0]   res_step;

  // previous row line store
  rbe_ram #(
    .WIDTH(rbe_pkg::PIXEL_W),
    .DEPTH(rbe_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // register writes, always ready
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= rbe_pkg::RST_FRAME_WIDTH;
      fh_r  <= rbe_pkg::RST_FRAME_HEIGHT;
      abs_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        rbe_pkg::CFG_FRAME_WIDTH:  fw_r  <= cfg_bus.data[rbe_pkg::FW_W-1:0];
        rbe_pkg::CFG_FRAME_HEIGHT: fh_r  <= cfg_bus.data[rbe_pkg::ROW_W-1:0];
        rbe_pkg::CFG_ABS_MODE:     abs_r <= cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (fw_r < rbe_pkg::FW_W'(rbe_pkg::MIN_DIM)) begin
      w_eff = rbe_pkg::FW_W'(rbe_pkg::MIN_DIM);
    end else if (fw_r > rbe_pkg::FW_W'(rbe_pkg::MAX_WIDTH)) begin
      w_eff = rbe_pkg::FW_W'(rbe_pkg::MAX_WIDTH);
    end else begin
      w_eff = fw_r;
    end
    if (fh_r < rbe_pkg::ROW_W'(rbe_pkg::MIN_DIM)) begin
      h_eff = rbe_pkg::ROW_W'(rbe_pkg::MIN_DIM);
    end else begin
      h_eff = fh_r;
    end
  end

  // position of the incoming pixel, wrapped against current geometry
  assign col_wrap = {1'b0, col_r} >= w_eff;
  assign row_step = col_wrap ? {1'b0, row_r} + (rbe_pkg::ROW_W+1)'(1) : {1'b0, row_r};
  assign c_sel    = col_wrap ? '0 : col_r;
  assign r_sel    = (row_step >= {1'b0, h_eff}) ? '0 : row_step[rbe_pkg::ROW_W-1:0];
  assign c_inc    = {1'b0, c_sel} + rbe_pkg::FW_W'(1);
  assign r_inc    = {1'b0, r_sel} + (rbe_pkg::ROW_W+1)'(1);

  // handshake helpers
  assign in_bus.ready = (state_r == rbe_pkg::ST_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;

  // window differences and their magnitudes
  assign d1 = {1'b0, pix_r} - {1'b0, left_above_r};
  assign d2 = {1'b0, left_now_r} - {1'b0, ram_rdata};
  assign a1 = d1[rbe_pkg::PIXEL_W] ? rbe_pkg::PIXEL_W'(-d1) : d1[rbe_pkg::PIXEL_W-1:0];
  assign a2 = d2[rbe_pkg::PIXEL_W] ? rbe_pkg::PIXEL_W'(-d2) : d2[rbe_pkg::PIXEL_W-1:0];

  // one step of the digit-by-digit square root
  assign root_try = {1'b0, res_r} + {1'b0, bit_r};
  assign root_ge  = {1'b0, rem_r} >= root_try;
  assign res_step = root_ge ? (res_r >> 1) + bit_r : res_r >> 1;

  // sequencer next state and datapath
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    left_now_nxt   = left_now_r;
    left_above_nxt = left_above_r;
    pix_nxt        = pix_r;
    addr_nxt       = addr_r;
    inner_nxt      = inner_r;
    last_nxt       = last_r;
    sq1_nxt        = sq1_r;
    sq2_nxt        = sq2_r;
    rem_nxt        = rem_r;
    res_nxt        = res_r;
    bit_nxt        = bit_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_edge_nxt   = out_edge_r;
    out_inner_nxt  = out_inner_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = pix_r;
    ram_raddr      = c_sel;

    case (state_r)
      rbe_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + rbe_pkg::COL_W'(1);
        if (clr_addr_r == rbe_pkg::COL_W'(rbe_pkg::MAX_WIDTH - 1)) begin
          state_nxt = rbe_pkg::ST_IDLE;
        end
      end
      rbe_pkg::ST_IDLE: begin
        if (in_acc) begin
          pix_nxt   = in_bus.pixel;
          addr_nxt  = c_sel;
          inner_nxt = (r_sel != '0) && (r_sel <= h_eff - rbe_pkg::ROW_W'(2)) &&
                      (c_sel != '0) && ({1'b0, c_sel} <= w_eff - rbe_pkg::FW_W'(2));
          last_nxt  = (r_sel == h_eff - rbe_pkg::ROW_W'(1)) &&
                      ({1'b0, c_sel} == w_eff - rbe_pkg::FW_W'(1));
          if (c_inc >= w_eff) begin
            col_nxt = '0;
            row_nxt = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[rbe_pkg::ROW_W-1:0];
          end else begin
            col_nxt = c_inc[rbe_pkg::COL_W-1:0];
            row_nxt = r_sel;
          end
          state_nxt = rbe_pkg::ST_CALC;
        end
      end
      rbe_pkg::ST_CALC: begin
        // pixel above is back from the store; update window and write back
        ram_we         = 1'b1;
        left_above_nxt = ram_rdata;
        left_now_nxt   = pix_r;
        sq1_nxt        = rbe_pkg::SQ_W'(a1) * rbe_pkg::SQ_W'(a1);
        sq2_nxt        = rbe_pkg::SQ_W'(a2) * rbe_pkg::SQ_W'(a2);
        if (!inner_r) begin
          val_nxt   = '0;
          state_nxt = rbe_pkg::ST_DONE;
        end else if (abs_r) begin
          val_nxt   = rbe_pkg::EDGE_W'(a1) + rbe_pkg::EDGE_W'(a2);
          state_nxt = rbe_pkg::ST_DONE;
        end else begin
          state_nxt = rbe_pkg::ST_SUM;
        end
      end
      rbe_pkg::ST_SUM: begin
        rem_nxt   = rbe_pkg::SUM_W'(sq1_r) + rbe_pkg::SUM_W'(sq2_r);
        res_nxt   = '0;
        bit_nxt   = rbe_pkg::ROOT_START;
        state_nxt = rbe_pkg::ST_ROOT;
      end
      rbe_pkg::ST_ROOT: begin
        if (root_ge) begin
          rem_nxt = rem_r - root_try[rbe_pkg::SUM_W-1:0];
        end
        res_nxt = res_step;
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          val_nxt   = res_step[rbe_pkg::EDGE_W-1:0];
          state_nxt = rbe_pkg::ST_DONE;
        end
      end
      rbe_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_edge_nxt  = val_r;
          out_inner_nxt = inner_r;
          out_last_nxt  = last_r;
          state_nxt     = rbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbe_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rbe_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      col_r        <= '0;
      row_r        <= '0;
      left_now_r   <= '0;
      left_above_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      left_now_r   <= left_now_nxt;
      left_above_r <= left_above_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pix_r       <= pix_nxt;
    addr_r      <= addr_nxt;
    inner_r     <= inner_nxt;
    last_r      <= last_nxt;
    sq1_r       <= sq1_nxt;
    sq2_r       <= sq2_nxt;
    rem_r       <= rem_nxt;
    res_r       <= res_nxt;
    bit_r       <= bit_nxt;
    val_r       <= val_nxt;
    out_edge_r  <= out_edge_nxt;
    out_inner_r <= out_inner_nxt;
    out_last_r  <= out_last_nxt;
  end

  // result channel
  assign out_bus.valid        = out_valid_r;
  assign out_bus.edge_value   = out_edge_r;
  assign out_bus.interior     = out_inner_r;
  assign out_bus.end_of_frame = out_last_r;

  // checks
  `ASSERT_NEXT(a_accept_reads, clk, rst_n, in_acc, state_r == rbe_pkg::ST_CALC, "accept did not start a read")
  `ASSERT_NEXT(a_col_range, clk, rst_n, in_acc, {1'b0, col_r} < $past(w_eff), "column past width")
  `ASSERT_ALWAYS(a_border_zero, clk, rst_n, out_bus.valid && !out_bus.interior |-> out_bus.edge_value == '0, "border result not zero")
  `ASSERT_ALWAYS(a_clear_blocks, clk, rst_n, state_r == rbe_pkg::ST_CLEAR |-> !in_bus.ready, "pixel taken during clear")

endmodule

`default_nettype wire
